[design/paa_pkg.sv]
package paa_pkg;

    localparam int CFG_W   = 9;
    localparam int LABEL_W = 8;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 9'd4;

    // Sideband that rides with a closed group to its result.
    typedef struct packed {
        logic               last;
        logic [LABEL_W-1:0] label;
    } paa_tag_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } paa_back_state_t;

endpackage

[design/paa_group_average_unit.sv]
// Group averager for six-channel motion samples (piecewise aggregate approximation).
// Input stream s_*: one sample per request; tdata holds the six Q4.11 channels,
// tuser the activity label, tlast the end-of-sequence mark.
// Output stream m_*: one request per closed group; tdata holds the six averages
// (sum / samples in group, truncated toward zero), tuser the label of the closing
// sample, tlast set when that sample ended the sequence.
// cfg_valid/cfg_data write group_size (0 acts as 1, above GROUP_MAX saturates);
// write it only while the block is idle.
// The front accumulates one sample per cycle while the queue has room and hands
// each closed group to a two-entry queue; the back divides all six channels in
// parallel over SUM_W-bit sums (SUM_W = SAMPLE_BITS + log2 GROUP_MAX), two quotient bits per cycle.
// m_tvalid rises once the group has passed the queue, the divider and the output
// register. The back takes a new group from the queue only once the last result
// has been loaded into the output register.
// When the receiver stalls the result holds in the output register, the back
// waits, and s_tready drops once both queue slots are taken.
// Reset clears the sums, the sample count and the queue, and sets group_size to 4.
module paa_group_average_unit #(
    parameter int CHANNELS    = 6,
    parameter int GROUP_MAX   = 256,
    parameter int SAMPLE_BITS = 16,
    localparam int TDATA_W    = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [TDATA_W-1:0]             s_tdata,   // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
    input  logic [paa_pkg::LABEL_W-1:0]    s_tuser,   // action_label
    input  logic                           s_tlast,   // end_of_sequence
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [TDATA_W-1:0]             m_tdata,   // avg_acc_x .. avg_gyro_z
    output logic [paa_pkg::LABEL_W-1:0]    m_tuser,   // label_out
    output logic                           m_tlast,   // last_of_sequence
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [paa_pkg::CFG_W-1:0]      cfg_data
);
    import paa_pkg::*;

    localparam int SUM_W   = SAMPLE_BITS + $clog2(GROUP_MAX);
    localparam int CNT_W   = $clog2(GROUP_MAX + 1);
    localparam int SUMS_W  = CHANNELS * SUM_W;
    localparam int ENTRY_W = SUMS_W + CNT_W + $bits(paa_tag_t);

    logic [CFG_W-1:0]   group_size_reg;
    logic               accept;
    paa_tag_t           tag_in;
    logic               push;
    logic [SUMS_W-1:0]  push_sums;
    logic [CNT_W-1:0]   push_count;
    paa_tag_t           push_tag;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_head;
    logic [CHANNELS*SAMPLE_BITS-1:0] m_avgs;
    paa_tag_t           m_tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            group_size_reg <= cfg_data;
        end
    end

    assign s_tready     = !q_full;
    assign accept       = s_tvalid && !q_full;
    assign tag_in.last  = s_tlast;
    assign tag_in.label = s_tuser;

    paa_front #(
        .CHANNELS    (CHANNELS),
        .GROUP_MAX   (GROUP_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .group_size (group_size_reg),
        .accept     (accept),
        .samples    (s_tdata[CHANNELS*SAMPLE_BITS-1:0]),
        .tag_in     (tag_in),
        .push       (push),
        .push_sums  (push_sums),
        .push_count (push_count),
        .push_tag   (push_tag)
    );

    paa_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_tag, push_count, push_sums}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    paa_back #(
        .CHANNELS    (CHANNELS),
        .GROUP_MAX   (GROUP_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_sums   (q_head[SUMS_W-1:0]),
        .q_count  (q_head[SUMS_W +: CNT_W]),
        .q_tag    (q_head[ENTRY_W-1 -: $bits(paa_tag_t)]),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_avgs   (m_avgs),
        .m_tag    (m_tag)
    );

    assign m_tdata = TDATA_W'(m_avgs);
    assign m_tuser = m_tag.label;
    assign m_tlast = m_tag.last;

endmodule

[design/paa_front.sv]
module paa_front #(
    parameter int CHANNELS    = 6,
    parameter int GROUP_MAX   = 256,
    parameter int SAMPLE_BITS = 16,
    localparam int SUM_W      = SAMPLE_BITS + $clog2(GROUP_MAX),
    localparam int CNT_W      = $clog2(GROUP_MAX + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [paa_pkg::CFG_W-1:0]          group_size,
    input  logic                               accept,
    input  logic [CHANNELS*SAMPLE_BITS-1:0]    samples,
    input  paa_pkg::paa_tag_t                  tag_in,
    output logic                               push,
    output logic [CHANNELS*SUM_W-1:0]          push_sums,
    output logic [CNT_W-1:0]                   push_count,
    output paa_pkg::paa_tag_t                  push_tag
);
    import paa_pkg::*;

    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [SUM_W-1:0] sum_reg  [CHANNELS];
    logic [SUM_W-1:0] sum_next [CHANNELS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] size_eff;
    logic [CMP_W-1:0] cnt_inc;
    logic             close;

    always_comb
    begin
        size_ext = CMP_W'(group_size);
        if (size_ext == '0)
        begin
            size_eff = CMP_W'(1);
        end
        else if (size_ext > CMP_W'(GROUP_MAX))
        begin
            size_eff = CMP_W'(GROUP_MAX);
        end
        else
        begin
            size_eff = size_ext;
        end
    end

    assign cnt_inc = CMP_W'(cnt_reg) + CMP_W'(1);
    assign close   = (cnt_inc >= size_eff) || tag_in.last;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic [SAMPLE_BITS-1:0] s;
        assign s           = samples[c*SAMPLE_BITS +: SAMPLE_BITS];
        assign sum_next[c] = sum_reg[c]
                           + {{(SUM_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
        assign push_sums[c*SUM_W +: SUM_W] = sum_next[c];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sum_reg[c] <= '0;
            end
            else if (accept)
            begin
                sum_reg[c] <= close ? '0 : sum_next[c];
            end
        end
    end

    assign push       = accept && close;
    assign push_count = CNT_W'(cnt_inc);
    assign push_tag   = tag_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= close ? '0 : CNT_W'(cnt_inc);
        end
    end

endmodule

[design/paa_queue.sv]
module paa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign valid = (fill_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

[design/paa_back.sv]
module paa_back #(
    parameter int CHANNELS    = 6,
    parameter int GROUP_MAX   = 256,
    parameter int SAMPLE_BITS = 16,
    localparam int SUM_W      = SAMPLE_BITS + $clog2(GROUP_MAX),
    localparam int CNT_W      = $clog2(GROUP_MAX + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  logic [CHANNELS*SUM_W-1:0]        q_sums,
    input  logic [CNT_W-1:0]                 q_count,
    input  paa_pkg::paa_tag_t                q_tag,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [CHANNELS*SAMPLE_BITS-1:0]  m_avgs,
    output paa_pkg::paa_tag_t                m_tag
);
    import paa_pkg::*;

    localparam int DIV_W  = ((SUM_W + 1) / 2) * 2;
    localparam int STEPS  = DIV_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    paa_back_state_t state_reg;
    paa_back_state_t state_next;
    logic            div_run;
    logic            out_load;

    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  div_reg;
    paa_tag_t          tag_reg;
    logic              m_tvalid_reg;
    logic [CHANNELS*SAMPLE_BITS-1:0] avg_reg;
    paa_tag_t          m_tag_reg;

    logic [DIV_W-1:0]  dq_reg  [CHANNELS];
    logic [CNT_W-1:0]  rem_reg [CHANNELS];
    logic              neg_reg [CHANNELS];
    logic [CHANNELS*SAMPLE_BITS-1:0] quot;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        div_run  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
            end
            BK_DIV:
            begin
                div_run = 1'b1;
            end
            BK_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                step_reg <= STEP_W'(STEPS);
            end
            else if (div_run)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            div_reg <= q_count;
            tag_reg <= q_tag;
        end
    end

    // Restoring divide of the magnitudes, two quotient bits per cycle.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] mag;
        logic [DIV_W-1:0] dq_step;
        logic [CNT_W-1:0] rem_step;
        logic [DIV_W-1:0] q_signed;

        assign sum = q_sums[c*SUM_W +: SUM_W];
        assign mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

        always_comb
        begin
            logic [CNT_W:0] shifted;
            dq_step  = dq_reg[c];
            rem_step = rem_reg[c];
            for (int k = 0; k < 2; k++)
            begin
                shifted = {rem_step, dq_step[DIV_W-1]};
                if (shifted >= {1'b0, div_reg})
                begin
                    rem_step = CNT_W'(shifted - {1'b0, div_reg});
                    dq_step  = {dq_step[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_step = shifted[CNT_W-1:0];
                    dq_step  = {dq_step[DIV_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (q_pop)
            begin
                dq_reg[c]  <= DIV_W'(mag);
                rem_reg[c] <= '0;
                neg_reg[c] <= sum[SUM_W-1];
            end
            else if (div_run)
            begin
                dq_reg[c]  <= dq_step;
                rem_reg[c] <= rem_step;
            end
        end

        assign q_signed = neg_reg[c] ? (~dq_reg[c] + DIV_W'(1)) : dq_reg[c];
        assign quot[c*SAMPLE_BITS +: SAMPLE_BITS] = q_signed[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            avg_reg   <= quot;
            m_tag_reg <= tag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_avgs   = avg_reg;
    assign m_tag    = m_tag_reg;

    a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> step_reg != '0)
        else $error("divider running with no steps left");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> div_reg != '0)
        else $error("group divided by a zero count");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == BK_DIV)
        else $error("popped group did not start dividing");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV && step_reg == STEP_W'(1)) |=> state_reg == BK_DONE)
        else $error("divider overran its last step");

endmodule
